// ===== design/brc_pkg.sv =====
// Shared types, codes and widths for the block residency controller.
package brc_pkg;

  localparam int unsigned ResW  = 3;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CondW = 4;

  // Residency states
  localparam logic [ResW-1:0] RS_NONE  = 3'd0;
  localparam logic [ResW-1:0] RS_MSET  = 3'd1;
  localparam logic [ResW-1:0] RS_MLOAD = 3'd2;
  localparam logic [ResW-1:0] RS_CREAT = 3'd3;
  localparam logic [ResW-1:0] RS_ASET  = 3'd4;
  localparam logic [ResW-1:0] RS_ALOAD = 3'd5;
  localparam logic [ResW-1:0] RS_AOK   = 3'd6;
  localparam logic [ResW-1:0] RS_DEL   = 3'd7;

  // Commands
  localparam logic [CmdW-1:0] CMD_NONE = 2'd0;
  localparam logic [CmdW-1:0] CMD_MAIN = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEC  = 2'd2;
  localparam logic [CmdW-1:0] CMD_DEL  = 2'd3;

  // Data unit orders
  localparam logic [OpW-1:0] OP_NONE  = 2'd0;
  localparam logic [OpW-1:0] OP_MAIN  = 2'd1;
  localparam logic [OpW-1:0] OP_SEC   = 2'd2;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd3;

  // Data unit condition codes
  localparam logic [CondW-1:0] DC_NONE  = 4'd0;
  localparam logic [CondW-1:0] DC_MLOAD = 4'd1;
  localparam logic [CondW-1:0] DC_MOK   = 4'd2;
  localparam logic [CondW-1:0] DC_ALOAD = 4'd3;
  localparam logic [CondW-1:0] DC_AOK   = 4'd4;
  localparam logic [CondW-1:0] DC_A2M   = 4'd5;
  localparam logic [CondW-1:0] DC_M2A   = 4'd6;
  localparam logic [CondW-1:0] DC_A2A   = 4'd7;
  localparam logic [CondW-1:0] DC_M2M   = 4'd8;

  typedef struct packed {
    logic [CmdW-1:0]  new_command;
    logic             load_arg;
    logic [CondW-1:0] data_condition;
    logic             others_ready;
    logic             pool_has_room;
  } item_t;

  typedef struct packed {
    logic [ResW-1:0] residency;
    logic [CmdW-1:0] pending_command;
    logic            saved_arg;
  } state_t;

  typedef struct packed {
    logic [ResW-1:0] residency_now;
    logic [CmdW-1:0] command_left;
    logic            unit_ready;
    logic [OpW-1:0]  issue_op;
    logic            issue_arg;
    logic            take_pool;
    logic            destroy_models;
    logic            create_models;
    logic            hide_models;
    logic            freeze_request;
  } result_t;

endpackage

// ===== design/brc_step.sv =====
// One frame step: command latch, command apply, condition advance, main load issue.
module brc_step (
  input  brc_pkg::item_t   item,
  input  brc_pkg::state_t  state,
  input  logic             no_mem_ctrl,
  output brc_pkg::state_t  state_nxt,
  output brc_pkg::result_t result
);

  always_comb begin
    logic [brc_pkg::ResW-1:0]  res;
    logic [brc_pkg::CmdW-1:0]  pend;
    logic                      arg;
    logic [brc_pkg::CondW-1:0] cond;
    logic [brc_pkg::OpW-1:0]   op;
    logic                      ready;
    logic                      take;
    logic                      destroy;
    logic                      create;
    logic                      hide;
    logic                      freeze;
    logic                      go;
    logic                      adv;

    res     = state.residency;
    pend    = state.pending_command;
    arg     = state.saved_arg;
    cond    = item.data_condition;
    op      = brc_pkg::OP_NONE;
    ready   = 1'b1;
    take    = 1'b0;
    destroy = 1'b0;
    create  = 1'b0;
    freeze  = 1'b0;
    go      = 1'b0;
    adv     = 1'b0;

    // Latch a new command with its argument
    if (item.new_command != brc_pkg::CMD_NONE) begin
      pend = item.new_command;
      arg  = item.load_arg;
    end
    hide = (pend == brc_pkg::CMD_SEC) || (pend == brc_pkg::CMD_DEL);

    // Apply pending command; a command hitting an in-flight transition stays queued
    unique case (pend)
      brc_pkg::CMD_MAIN: begin
        if (res == brc_pkg::RS_NONE || res == brc_pkg::RS_AOK) begin
          res  = brc_pkg::RS_MSET;
          pend = brc_pkg::CMD_NONE;
        end else if (res == brc_pkg::RS_MSET || res == brc_pkg::RS_MLOAD ||
                     res == brc_pkg::RS_CREAT) begin
          pend = brc_pkg::CMD_NONE;
        end
      end
      brc_pkg::CMD_SEC: begin
        if (res == brc_pkg::RS_CREAT || res == brc_pkg::RS_NONE) begin
          destroy = (res == brc_pkg::RS_CREAT);
          res     = brc_pkg::RS_ASET;
          pend    = brc_pkg::CMD_NONE;
        end else if (res == brc_pkg::RS_ASET || res == brc_pkg::RS_ALOAD ||
                     res == brc_pkg::RS_AOK) begin
          pend = brc_pkg::CMD_NONE;
        end
      end
      brc_pkg::CMD_DEL: begin
        if (res == brc_pkg::RS_CREAT || res == brc_pkg::RS_NONE ||
            res == brc_pkg::RS_AOK || res == brc_pkg::RS_DEL) begin
          destroy = (res == brc_pkg::RS_CREAT);
          res     = brc_pkg::RS_DEL;
          pend    = brc_pkg::CMD_NONE;
        end
      end
      default: begin
      end
    endcase

    // Advance from the data unit condition
    unique case (res)
      brc_pkg::RS_MLOAD: begin
        ready = 1'b0;
        if (cond == brc_pkg::DC_NONE || cond == brc_pkg::DC_MLOAD) begin
          freeze = 1'b1;
        end else if (cond == brc_pkg::DC_MOK) begin
          create = 1'b1;
          res    = brc_pkg::RS_CREAT;
          ready  = 1'b1;
        end
      end
      brc_pkg::RS_ASET: begin
        ready = 1'b0;
        if (cond == brc_pkg::DC_NONE || cond == brc_pkg::DC_MOK) begin
          op    = brc_pkg::OP_SEC;
          res   = brc_pkg::RS_ALOAD;
          ready = (cond == brc_pkg::DC_NONE);
        end else if (cond == brc_pkg::DC_M2A) begin
          res = brc_pkg::RS_ALOAD;
        end else if (cond == brc_pkg::DC_ALOAD || cond == brc_pkg::DC_AOK ||
                     cond == brc_pkg::DC_A2A) begin
          res   = brc_pkg::RS_ALOAD;
          ready = 1'b1;
        end
      end
      brc_pkg::RS_ALOAD: begin
        ready = 1'b0;
        if (cond == brc_pkg::DC_AOK) begin
          res   = brc_pkg::RS_AOK;
          ready = 1'b1;
        end else if (cond == brc_pkg::DC_ALOAD || cond == brc_pkg::DC_A2A) begin
          ready = 1'b1;
        end
      end
      brc_pkg::RS_DEL: begin
        ready = 1'b0;
        if (cond == brc_pkg::DC_NONE || cond == brc_pkg::DC_MOK ||
            cond == brc_pkg::DC_AOK) begin
          op    = brc_pkg::OP_CLEAR;
          res   = brc_pkg::RS_NONE;
          ready = 1'b1;
        end else if (cond == brc_pkg::DC_ALOAD || cond == brc_pkg::DC_A2A) begin
          ready = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Issue the main load once everyone is ready, gated by pool room unless no_mem_ctrl is set
    if (ready && item.others_ready && res == brc_pkg::RS_MSET) begin
      if (cond == brc_pkg::DC_NONE || cond == brc_pkg::DC_MLOAD) begin
        freeze = 1'b1;
      end
      if (cond == brc_pkg::DC_NONE || cond == brc_pkg::DC_MLOAD ||
          cond == brc_pkg::DC_AOK) begin
        if (no_mem_ctrl) begin
          go = 1'b1;
        end else if (item.pool_has_room) begin
          go   = 1'b1;
          take = 1'b1;
        end
        adv = go;
      end else if (cond == brc_pkg::DC_MOK || cond == brc_pkg::DC_A2M ||
                   cond == brc_pkg::DC_M2M) begin
        adv = 1'b1;
      end else if (cond == brc_pkg::DC_ALOAD || cond == brc_pkg::DC_M2A ||
                   cond == brc_pkg::DC_A2A) begin
        freeze = 1'b1;
      end
      if (go) begin
        op = brc_pkg::OP_MAIN;
      end
      if (adv) begin
        res = brc_pkg::RS_MLOAD;
      end
    end

    state_nxt.residency       = res;
    state_nxt.pending_command = pend;
    state_nxt.saved_arg       = arg;

    result.residency_now  = res;
    result.command_left   = pend;
    result.unit_ready     = ready;
    result.issue_op       = op;
    result.issue_arg      = (op == brc_pkg::OP_MAIN || op == brc_pkg::OP_SEC) ? arg : 1'b0;
    result.take_pool      = take;
    result.destroy_models = destroy;
    result.create_models  = create;
    result.hide_models    = hide;
    result.freeze_request = freeze;
  end

endmodule

// ===== design/block_residency_controller.sv =====
// Top level of the block residency controller: input register, step logic, result register.
// Takes one frame item per clock while in_stall is low. An accepted item is held in the input
// register, moves into the result register when that register is empty or being drained, and
// is offered on the out_ ports from then on. The residency state is updated as an item moves
// into the result register, so each item sees the state left by the one before it. The
// single-pass step logic between the two registers sets the rate of one item per cycle while
// out_stall is low. in_stall rises only when both registers are full and out_stall is high.
// The cfg port is always ready; write no_mem_ctrl only while no item is in flight.
module block_residency_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_no_mem_ctrl,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [brc_pkg::CmdW-1:0]   in_new_command,
  input  logic                       in_load_arg,
  input  logic [brc_pkg::CondW-1:0]  in_data_condition,
  input  logic                       in_others_ready,
  input  logic                       in_pool_has_room,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brc_pkg::ResW-1:0]   out_residency_now,
  output logic [brc_pkg::CmdW-1:0]   out_command_left,
  output logic                       out_unit_ready,
  output logic [brc_pkg::OpW-1:0]    out_issue_op,
  output logic                       out_issue_arg,
  output logic                       out_take_pool,
  output logic                       out_destroy_models,
  output logic                       out_create_models,
  output logic                       out_hide_models,
  output logic                       out_freeze_request
);

  logic              no_mem_ctrl_r;
  logic              s1_valid_r;
  brc_pkg::item_t    s1_item_r;
  brc_pkg::state_t   state_r;
  brc_pkg::state_t   state_nxt;
  logic              out_valid_r;
  brc_pkg::result_t  out_r;
  brc_pkg::result_t  result_nxt;
  logic              out_load;
  logic              s1_load;

  assign cfg_ready = 1'b1;

  // Result register takes a new item when empty or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign s1_load  = !in_stall;

  brc_step u_step (
    .item        (s1_item_r),
    .state       (state_r),
    .no_mem_ctrl (no_mem_ctrl_r),
    .state_nxt   (state_nxt),
    .result      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_mem_ctrl_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      no_mem_ctrl_r <= cfg_no_mem_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      // Commit the step only when the item moves on
      if (out_load && s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r.new_command    <= in_new_command;
      s1_item_r.load_arg       <= in_load_arg;
      s1_item_r.data_condition <= in_data_condition;
      s1_item_r.others_ready   <= in_others_ready;
      s1_item_r.pool_has_room  <= in_pool_has_room;
    end
    if (out_load && s1_valid_r) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_residency_now  = out_r.residency_now;
  assign out_command_left   = out_r.command_left;
  assign out_unit_ready     = out_r.unit_ready;
  assign out_issue_op       = out_r.issue_op;
  assign out_issue_arg      = out_r.issue_arg;
  assign out_take_pool      = out_r.take_pool;
  assign out_destroy_models = out_r.destroy_models;
  assign out_create_models  = out_r.create_models;
  assign out_hide_models    = out_r.hide_models;
  assign out_freeze_request = out_r.freeze_request;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for block_residency_controller: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned PhaseItems = 250;
  // condition codes past the last defined one
  localparam logic [brc_pkg::CondW-1:0] CondBad = 4'd9;
  localparam logic [brc_pkg::CondW-1:0] CondTop = 4'd15;

  typedef struct {
    brc_pkg::item_t   stim;
    bit               typed;
    brc_pkg::result_t want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_no_mem_ctrl = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [brc_pkg::CmdW-1:0]  in_new_command = brc_pkg::CMD_NONE;
  logic                      in_load_arg = 1'b0;
  logic [brc_pkg::CondW-1:0] in_data_condition = brc_pkg::DC_NONE;
  logic                      in_others_ready = 1'b0;
  logic                      in_pool_has_room = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [brc_pkg::ResW-1:0]  out_residency_now;
  logic [brc_pkg::CmdW-1:0]  out_command_left;
  logic                      out_unit_ready;
  logic [brc_pkg::OpW-1:0]   out_issue_op;
  logic                      out_issue_arg;
  logic                      out_take_pool;
  logic                      out_destroy_models;
  logic                      out_create_models;
  logic                      out_hide_models;
  logic                      out_freeze_request;

  // predicted block state and register copy
  logic [brc_pkg::ResW-1:0]  blk_res = brc_pkg::RS_NONE;
  logic [brc_pkg::CmdW-1:0]  blk_cmd = brc_pkg::CMD_NONE;
  logic                      blk_arg = 1'b0;
  logic                      cfg_nomem = 1'b0;

  brc_pkg::result_t expect_q[$];
  stim_row_t        dir_rows[$];
  brc_pkg::result_t head;
  brc_pkg::result_t got;
  int unsigned      n_fail = 0;
  int unsigned      n_results = 0;
  int unsigned      n_cycles = 0;
  int unsigned      hold_left = 0;
  int unsigned      hold_at = 200;
  bit               calm = 1'b0;

  block_residency_controller DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_no_mem_ctrl    (cfg_no_mem_ctrl),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_new_command     (in_new_command),
    .in_load_arg        (in_load_arg),
    .in_data_condition  (in_data_condition),
    .in_others_ready    (in_others_ready),
    .in_pool_has_room   (in_pool_has_room),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_residency_now  (out_residency_now),
    .out_command_left   (out_command_left),
    .out_unit_ready     (out_unit_ready),
    .out_issue_op       (out_issue_op),
    .out_issue_arg      (out_issue_arg),
    .out_take_pool      (out_take_pool),
    .out_destroy_models (out_destroy_models),
    .out_create_models  (out_create_models),
    .out_hide_models    (out_hide_models),
    .out_freeze_request (out_freeze_request)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One frame step: latch command, apply it, advance from the data unit, then try the main load.
  function automatic brc_pkg::result_t step_residency(input brc_pkg::item_t it);
    brc_pkg::result_t          r;
    logic                      rdy;
    logic                      go;
    logic                      adv;
    logic [brc_pkg::CondW-1:0] c;
    r = '0;
    rdy = 1'b1;
    go = 1'b0;
    adv = 1'b0;
    c = it.data_condition;
    if (it.new_command != brc_pkg::CMD_NONE) begin
      blk_cmd = it.new_command;
      blk_arg = it.load_arg;
    end
    r.hide_models = (blk_cmd == brc_pkg::CMD_SEC || blk_cmd == brc_pkg::CMD_DEL);

    // a command meeting a transition in flight stays pending
    case (blk_cmd)
      brc_pkg::CMD_MAIN: begin
        if (blk_res == brc_pkg::RS_NONE || blk_res == brc_pkg::RS_AOK) begin
          blk_res = brc_pkg::RS_MSET;
          blk_cmd = brc_pkg::CMD_NONE;
        end else if (blk_res inside {brc_pkg::RS_MSET, brc_pkg::RS_MLOAD,
                                     brc_pkg::RS_CREAT}) begin
          blk_cmd = brc_pkg::CMD_NONE;
        end
      end
      brc_pkg::CMD_SEC: begin
        if (blk_res == brc_pkg::RS_CREAT || blk_res == brc_pkg::RS_NONE) begin
          r.destroy_models = (blk_res == brc_pkg::RS_CREAT);
          blk_res = brc_pkg::RS_ASET;
          blk_cmd = brc_pkg::CMD_NONE;
        end else if (blk_res inside {brc_pkg::RS_ASET, brc_pkg::RS_ALOAD,
                                     brc_pkg::RS_AOK}) begin
          blk_cmd = brc_pkg::CMD_NONE;
        end
      end
      brc_pkg::CMD_DEL: begin
        if (blk_res inside {brc_pkg::RS_CREAT, brc_pkg::RS_NONE, brc_pkg::RS_AOK,
                            brc_pkg::RS_DEL}) begin
          r.destroy_models = (blk_res == brc_pkg::RS_CREAT);
          blk_res = brc_pkg::RS_DEL;
          blk_cmd = brc_pkg::CMD_NONE;
        end
      end
      default: ;
    endcase

    case (blk_res)
      brc_pkg::RS_MLOAD: begin
        rdy = 1'b0;
        if (c == brc_pkg::DC_NONE || c == brc_pkg::DC_MLOAD) begin
          r.freeze_request = 1'b1;
        end else if (c == brc_pkg::DC_MOK) begin
          r.create_models = 1'b1;
          blk_res = brc_pkg::RS_CREAT;
          rdy = 1'b1;
        end
      end
      brc_pkg::RS_ASET: begin
        rdy = 1'b0;
        if (c == brc_pkg::DC_NONE || c == brc_pkg::DC_MOK) begin
          r.issue_op = brc_pkg::OP_SEC;
          blk_res = brc_pkg::RS_ALOAD;
          rdy = (c == brc_pkg::DC_NONE);
        end else if (c == brc_pkg::DC_M2A) begin
          blk_res = brc_pkg::RS_ALOAD;
        end else if (c inside {brc_pkg::DC_ALOAD, brc_pkg::DC_AOK, brc_pkg::DC_A2A}) begin
          blk_res = brc_pkg::RS_ALOAD;
          rdy = 1'b1;
        end
      end
      brc_pkg::RS_ALOAD: begin
        rdy = 1'b0;
        if (c == brc_pkg::DC_AOK) begin
          blk_res = brc_pkg::RS_AOK;
          rdy = 1'b1;
        end else if (c == brc_pkg::DC_ALOAD || c == brc_pkg::DC_A2A) begin
          rdy = 1'b1;
        end
      end
      brc_pkg::RS_DEL: begin
        rdy = 1'b0;
        if (c inside {brc_pkg::DC_NONE, brc_pkg::DC_MOK, brc_pkg::DC_AOK}) begin
          r.issue_op = brc_pkg::OP_CLEAR;
          blk_res = brc_pkg::RS_NONE;
          rdy = 1'b1;
        end else if (c == brc_pkg::DC_ALOAD || c == brc_pkg::DC_A2A) begin
          rdy = 1'b1;
        end
      end
      default: ;
    endcase

    if (rdy && it.others_ready && blk_res == brc_pkg::RS_MSET) begin
      if (c == brc_pkg::DC_NONE || c == brc_pkg::DC_MLOAD) r.freeze_request = 1'b1;
      if (c inside {brc_pkg::DC_NONE, brc_pkg::DC_MLOAD, brc_pkg::DC_AOK}) begin
        if (cfg_nomem) begin
          go = 1'b1;
        end else if (it.pool_has_room) begin
          go = 1'b1;
          r.take_pool = 1'b1;
        end
        adv = go;
      end else if (c inside {brc_pkg::DC_MOK, brc_pkg::DC_A2M, brc_pkg::DC_M2M}) begin
        adv = 1'b1;
      end else if (c inside {brc_pkg::DC_ALOAD, brc_pkg::DC_M2A, brc_pkg::DC_A2A}) begin
        r.freeze_request = 1'b1;
      end
      if (go) r.issue_op = brc_pkg::OP_MAIN;
      if (adv) blk_res = brc_pkg::RS_MLOAD;
    end

    r.residency_now = blk_res;
    r.command_left = blk_cmd;
    r.unit_ready = rdy;
    r.issue_arg = (r.issue_op == brc_pkg::OP_MAIN || r.issue_op == brc_pkg::OP_SEC) ?
                  blk_arg : 1'b0;
    return r;
  endfunction

  // Random item, steered toward conditions that move the current state along.
  function automatic brc_pkg::item_t pick_item();
    brc_pkg::item_t            it;
    logic [brc_pkg::CondW-1:0] opts[$];
    int unsigned               cmd_pct;
    cmd_pct = (blk_res inside {brc_pkg::RS_NONE, brc_pkg::RS_CREAT, brc_pkg::RS_AOK}) ?
              45 : 15;
    it.new_command = ($urandom_range(99) < cmd_pct) ?
                     brc_pkg::CmdW'($urandom_range(3, 1)) : brc_pkg::CMD_NONE;
    it.load_arg = 1'($urandom_range(1));
    it.others_ready = ($urandom_range(99) < 85);
    it.pool_has_room = ($urandom_range(99) < 70);
    case (blk_res)
      brc_pkg::RS_MSET:  opts = {brc_pkg::DC_NONE, brc_pkg::DC_MLOAD, brc_pkg::DC_AOK,
                                 brc_pkg::DC_MOK, brc_pkg::DC_A2M, brc_pkg::DC_M2M};
      brc_pkg::RS_MLOAD: opts = {brc_pkg::DC_MOK, brc_pkg::DC_MOK, brc_pkg::DC_NONE};
      brc_pkg::RS_ASET:  opts = {brc_pkg::DC_NONE, brc_pkg::DC_MOK, brc_pkg::DC_ALOAD,
                                 brc_pkg::DC_AOK, brc_pkg::DC_M2A, brc_pkg::DC_A2A};
      brc_pkg::RS_ALOAD: opts = {brc_pkg::DC_AOK, brc_pkg::DC_ALOAD, brc_pkg::DC_A2A};
      brc_pkg::RS_DEL:   opts = {brc_pkg::DC_NONE, brc_pkg::DC_MOK, brc_pkg::DC_AOK,
                                 brc_pkg::DC_ALOAD};
      default:           opts = {brc_pkg::DC_NONE, brc_pkg::DC_AOK};
    endcase
    if ($urandom_range(99) < 6) begin
      it.data_condition = brc_pkg::CondW'($urandom_range(15, 9));
    end else if ($urandom_range(99) < 40) begin
      it.data_condition = brc_pkg::CondW'($urandom_range(8, 0));
    end else begin
      it.data_condition = opts[$urandom_range(opts.size() - 1)];
    end
    return it;
  endfunction

  task automatic add_row(input brc_pkg::item_t stim, input bit typed,
                         input brc_pkg::result_t want);
    stim_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Offer one item, hold it until taken, then maybe idle a little.
  task automatic send_item(input brc_pkg::item_t it, input bit typed,
                           input brc_pkg::result_t want);
    brc_pkg::result_t pred;
    in_valid <= 1'b1;
    in_new_command <= it.new_command;
    in_load_arg <= it.load_arg;
    in_data_condition <= it.data_condition;
    in_others_ready <= it.others_ready;
    in_pool_has_room <= it.pool_has_room;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = step_residency(it);
    expect_q.push_back(typed ? want : pred);
    if (!calm && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_nomem(input logic v);
    cfg_valid <= 1'b1;
    cfg_no_mem_ctrl <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_nomem = v;
  endtask

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] actual);
    if (want !== actual) begin
      $error("%s: expected %0d, got %0d", name, want, actual);
      n_fail++;
    end
  endfunction

  // Result side: check each accepted item, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      got = '{out_residency_now, out_command_left, out_unit_ready, out_issue_op,
              out_issue_arg, out_take_pool, out_destroy_models, out_create_models,
              out_hide_models, out_freeze_request};
      if (expect_q.size() == 0) begin
        $error("result item arrived with nothing expected");
        n_fail++;
      end else begin
        head = expect_q.pop_front();
        check_field("residency_now", 4'(head.residency_now), 4'(got.residency_now));
        check_field("command_left", 4'(head.command_left), 4'(got.command_left));
        check_field("unit_ready", 4'(head.unit_ready), 4'(got.unit_ready));
        check_field("issue_op", 4'(head.issue_op), 4'(got.issue_op));
        check_field("issue_arg", 4'(head.issue_arg), 4'(got.issue_arg));
        check_field("take_pool", 4'(head.take_pool), 4'(got.take_pool));
        check_field("destroy_models", 4'(head.destroy_models), 4'(got.destroy_models));
        check_field("create_models", 4'(head.create_models), 4'(got.create_models));
        check_field("hide_models", 4'(head.hide_models), 4'(got.hide_models));
        check_field("freeze_request", 4'(head.freeze_request), 4'(got.freeze_request));
      end
    end
    // long hold-off lets the block fill and stall its input
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (n_results >= hold_at) begin
      hold_at += 500;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && !calm && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $error("run did not finish within %0d cycles", CycleLimit);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_nomem(1'b0);

    // state right after reset
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b1, brc_pkg::DC_NONE, 1'b1, 1'b1}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_NONE, brc_pkg::CMD_NONE, 1'b1, brc_pkg::OP_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // main load with the top condition code: no transition from it
    add_row(brc_pkg::item_t'{brc_pkg::CMD_MAIN, 1'b1, CondTop, 1'b1, 1'b1}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_MSET, brc_pkg::CMD_NONE, 1'b1, brc_pkg::OP_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // no pool room: hold in main-load-set, freeze still reported
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_NONE, 1'b1, 1'b0}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_MSET, brc_pkg::CMD_NONE, 1'b1, brc_pkg::OP_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_MLOAD, 1'b1, 1'b1}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_MLOAD, brc_pkg::CMD_NONE, 1'b1, brc_pkg::OP_MAIN,
                               1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1});
    // secondary load blocked while the main load is in flight
    add_row(brc_pkg::item_t'{brc_pkg::CMD_SEC, 1'b0, brc_pkg::DC_MLOAD, 1'b1, 1'b1}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_MLOAD, brc_pkg::CMD_SEC, 1'b0, brc_pkg::OP_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_MOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_AOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b1, brc_pkg::DC_AOK, 1'b0, 1'b0}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_DEL, 1'b1, brc_pkg::DC_A2A, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_NONE, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_SEC, 1'b1, brc_pkg::DC_NONE, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_MAIN, 1'b0, brc_pkg::DC_M2A, 1'b1, 1'b1}, 1'b0, '0);
    // first undefined condition code counts as not ready
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, CondBad, 1'b1, 1'b1}, 1'b1,
            brc_pkg::result_t'{brc_pkg::RS_ALOAD, brc_pkg::CMD_MAIN, 1'b0, brc_pkg::OP_NONE,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_AOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_A2M, 1'b1, 1'b0}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_DEL, 1'b0, brc_pkg::DC_M2M, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_MOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_ALOAD, 1'b1, 1'b1}, 1'b0,
            '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_AOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_MAIN, 1'b1, brc_pkg::DC_ALOAD, 1'b0, 1'b1}, 1'b0,
            '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_M2A, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_MAIN, 1'b0, brc_pkg::DC_AOK, 1'b1, 1'b0}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_NONE, 1'b0, brc_pkg::DC_AOK, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_SEC, 1'b1, brc_pkg::DC_NONE, 1'b1, 1'b1}, 1'b0, '0);
    add_row(brc_pkg::item_t'{brc_pkg::CMD_DEL, 1'b1, CondTop, 1'b1, 1'b1}, 1'b0, '0);

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // random phases alternate the pool-control bit between its two values
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_nomem(ph % 2 == 0);
      for (int k = 0; k < PhaseItems; k++) begin
        calm = (ph == 1 && k < 150);
        send_item(pick_item(), 1'b0, '0);
        if (ph == 1 && k == 200) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (expect_q.size() != 0) begin
      $error("%0d result items never arrived", expect_q.size());
      n_fail++;
    end
    if (n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/brc_pkg.sv
design/brc_step.sv
design/block_residency_controller.sv
sim/testbench.sv
